/* rtl/swpd_pkg.sv */
// swpd_pkg: shared types, codes and sizes for the stack with delete by priority.
// Used by swpd_ctrl, swpd_dp and stack_with_priority_delete. No dependencies.
`default_nettype none

package swpd_pkg;

    // Stack depth and derived widths
    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Command codes
    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_LIST   = 2'd2;

    // Result status codes
    localparam logic [2:0] ST_PUSHED   = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_REMOVED  = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;
    localparam logic [2:0] ST_LISTED   = 3'd5;

    // Input beat
    typedef struct packed {
        logic [1:0]         command;
        logic signed [31:0] value;
        logic [7:0]         priority_req;
    } t_cmd_in;

    // Result beat
    typedef struct packed {
        logic [2:0]         status;
        logic signed [31:0] value_res;
        logic [7:0]         priority_out;
        logic               last;
    } t_result;

    // Controller to datapath commands
    typedef struct packed {
        logic       push;
        logic       match_load;
        logic       remove;
        logic       list_load;
        logic       list_step;
        logic       emit;
        logic       emit_entry;
        logic [2:0] status;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic full;
        logic empty;
        logic found;
        logic list_last;
    } t_dp_stat;

endpackage

`default_nettype wire

/* rtl/stack_with_priority_delete.sv */
// stack_with_priority_delete: bounded stack of (value, priority) entries with
// delete of the topmost entry of a given priority. Uses swpd_pkg, swpd_ctrl, swpd_dp.
//
//   channel   ports                     handshake
//   command   i_cmd                     taken when start is high and busy is low
//   result    o_result                  one beat per cycle o_valid is high
//
// Push: result in the cycle after; busy stays low, so pushes can follow back to back.
// Remove: a compare step loads the registered match vector, then an encode/shift
// step follows in S_REMOVE. List: load the pointer, then one beat per entry.
// Reset (i_rst_n low, synchronous) empties the stack; entry contents are not cleared.
// The receiver cannot stall: every result beat is shown for exactly one cycle.
`default_nettype none

module stack_with_priority_delete (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               start,
    input  swpd_pkg::t_cmd_in i_cmd,
    output logic              busy,
    output logic              o_valid,
    output swpd_pkg::t_result o_result
);
    import swpd_pkg::*;

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer
    swpd_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .i_command (i_cmd.command),
        .i_stat    (dp_stat),
        .o_busy    (busy),
        .o_dp_cmd  (dp_cmd)
    );

    // Store and result path
    swpd_dp u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_dp_cmd (dp_cmd),
        .o_stat   (dp_stat),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

endmodule

`default_nettype wire

/* rtl/swpd_dp.sv */
// swpd_dp: entry store, match vector, list pointer and result register.
// Depends on swpd_pkg; driven by commands from swpd_ctrl.
`default_nettype none

module swpd_dp (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  swpd_pkg::t_cmd_in  i_cmd,
    input  swpd_pkg::t_dp_cmd  i_dp_cmd,
    output swpd_pkg::t_dp_stat o_stat,
    output logic               o_valid,
    output swpd_pkg::t_result  o_result
);
    import swpd_pkg::*;

    logic signed [31:0] r_val [DEPTH];
    logic [7:0]         r_pri [DEPTH];
    logic [CNT_W-1:0]   r_count;
    logic [DEPTH-1:0]   r_match;
    logic [IDX_W-1:0]   r_idx;
    logic               r_valid;
    t_result            r_result;

    logic [IDX_W-1:0]   hit_slot;
    logic               full;
    logic               empty;
    logic               found;
    logic [IDX_W-1:0]   top_idx;

    assign full    = (r_count == CNT_W'(DEPTH));
    assign empty   = (r_count == '0);
    assign found   = |r_match;
    assign top_idx = IDX_W'(r_count - CNT_W'(1));

    // Pick the topmost matching slot
    always_comb begin
        hit_slot = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (r_match[i]) begin
                hit_slot = IDX_W'(i);
            end
        end
    end

    // Store: push on top, close the gap on remove
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DEPTH; k++) begin
            if (i_dp_cmd.push && !full && (r_count[IDX_W-1:0] == IDX_W'(k))) begin
                r_val[k] <= i_cmd.value;
                r_pri[k] <= i_cmd.priority_req;
            end else if (i_dp_cmd.remove && found && (k < DEPTH - 1)
                         && (IDX_W'(k) >= hit_slot)) begin
                r_val[k] <= r_val[(k + 1) % DEPTH];
                r_pri[k] <= r_pri[(k + 1) % DEPTH];
            end
        end
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_dp_cmd.push && !full) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_dp_cmd.remove && found) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    // Compare all live entries against the requested priority
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.match_load) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_match[i] <= (r_pri[i] == i_cmd.priority_req)
                              && (CNT_W'(i) < r_count);
            end
        end
    end

    // List pointer walks from top to bottom
    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.list_load) begin
            r_idx <= top_idx;
        end else if (i_dp_cmd.list_step) begin
            r_idx <= r_idx - IDX_W'(1);
        end
    end

    // Result register: one beat per emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_dp_cmd.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_dp_cmd.emit) begin
            r_result.status <= i_dp_cmd.status;
            if (i_dp_cmd.emit_entry) begin
                r_result.value_res    <= r_val[r_idx];
                r_result.priority_out <= r_pri[r_idx];
                r_result.last         <= (r_idx == '0);
            end else begin
                r_result.value_res    <= '0;
                r_result.priority_out <= '0;
                r_result.last         <= 1'b1;
            end
        end
    end

    assign o_stat.full      = full;
    assign o_stat.empty     = empty;
    assign o_stat.found     = found;
    assign o_stat.list_last = (r_idx == '0);
    assign o_valid          = r_valid;
    assign o_result         = r_result;

endmodule

`default_nettype wire

/* rtl/swpd_ctrl.sv */
// swpd_ctrl: command decode and sequencing for push, remove and list.
// Depends on swpd_pkg; drives swpd_dp through t_dp_cmd.
`default_nettype none

module swpd_ctrl (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wire [1:0]          i_command,
    input  swpd_pkg::t_dp_stat i_stat,
    output logic               o_busy,
    output swpd_pkg::t_dp_cmd  o_dp_cmd
);
    import swpd_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_REMOVE = 2'd1;
    localparam logic [1:0] S_LIST   = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Decode and sequence
    always_comb begin
        n_state  = r_state;
        o_dp_cmd = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_command)
                        CMD_PUSH: begin
                            o_dp_cmd.push   = 1'b1;
                            o_dp_cmd.emit   = 1'b1;
                            o_dp_cmd.status = i_stat.full ? ST_FULL : ST_PUSHED;
                        end
                        CMD_REMOVE: begin
                            if (i_stat.empty) begin
                                o_dp_cmd.emit   = 1'b1;
                                o_dp_cmd.status = ST_EMPTY;
                            end else begin
                                o_dp_cmd.match_load = 1'b1;
                                n_state             = S_REMOVE;
                            end
                        end
                        CMD_LIST: begin
                            if (i_stat.empty) begin
                                o_dp_cmd.emit   = 1'b1;
                                o_dp_cmd.status = ST_EMPTY;
                            end else begin
                                o_dp_cmd.list_load = 1'b1;
                                n_state            = S_LIST;
                            end
                        end
                        default: begin
                            // drop the unused command
                        end
                    endcase
                end
            end
            S_REMOVE: begin
                o_dp_cmd.remove = i_stat.found;
                o_dp_cmd.emit   = 1'b1;
                o_dp_cmd.status = i_stat.found ? ST_REMOVED : ST_NOTFOUND;
                n_state         = S_IDLE;
            end
            S_LIST: begin
                o_dp_cmd.emit       = 1'b1;
                o_dp_cmd.emit_entry = 1'b1;
                o_dp_cmd.list_step  = 1'b1;
                o_dp_cmd.status     = ST_LISTED;
                if (i_stat.list_last) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

`default_nettype wire

/* sim/tb_stack_with_priority_delete.sv */
// tb_stack_with_priority_delete: self-checking testbench for the bounded stack with
// delete by priority. It predicts every result beat from a shadow copy of the stack.
// Depends on rtl/swpd_pkg.sv and rtl/stack_with_priority_delete.sv.
`timescale 1ns / 100ps

module tb_stack_with_priority_delete;

    import swpd_pkg::*;

    // Command code that the block ignores
    localparam logic [1:0] CMD_UNUSED = 2'd3;
    // Cycles without any beat before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    // Cycles to watch for stray beats once nothing is outstanding
    localparam int DRAIN_CYCLES = 40;

    logic    i_clk = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    start = 1'b0;
    t_cmd_in i_cmd = '0;
    logic    busy;
    logic    o_valid;
    t_result o_result;

    // Shadow copy of the stack; slot 0 is the bottom
    logic signed [31:0] shadow_value [DEPTH];
    logic [7:0]         shadow_prio [DEPTH];
    int                 shadow_count = 0;

    // Result beats still owed by the block, oldest first
    t_result pending_results [$];

    int errors = 0;
    int items_sent = 0;
    int results_seen = 0;
    int refused_pushes = 0;
    int removals = 0;
    int peak_depth = 0;
    int quiet_cycles = 0;

    stack_with_priority_delete dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_cmd    (i_cmd),
        .busy     (busy),
        .o_valid  (o_valid),
        .o_result (o_result)
    );

    always #1 i_clk = ~i_clk;

    // Apply one accepted command to the shadow stack and queue the beats it owes
    function automatic void compute_stack_response(input t_cmd_in c);
        t_result r;
        int      hit_slot;
        r = '0;
        r.last = 1'b1;
        hit_slot = -1;
        case (c.command)
            CMD_PUSH: begin
                if (shadow_count >= DEPTH) begin
                    r.status = ST_FULL;
                    refused_pushes++;
                end else begin
                    shadow_value[shadow_count] = c.value;
                    shadow_prio[shadow_count] = c.priority_req;
                    shadow_count++;
                    if (shadow_count > peak_depth) peak_depth = shadow_count;
                    r.status = ST_PUSHED;
                end
                pending_results.push_back(r);
            end
            CMD_REMOVE: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    // search from the top, take only the first match
                    for (int i = shadow_count - 1; i >= 0; i--) begin
                        if (hit_slot < 0 && shadow_prio[i] == c.priority_req) hit_slot = i;
                    end
                    if (hit_slot < 0) begin
                        r.status = ST_NOTFOUND;
                    end else begin
                        // close the gap, keep the order of the rest
                        for (int k = hit_slot; k + 1 < shadow_count; k++) begin
                            shadow_value[k] = shadow_value[k + 1];
                            shadow_prio[k] = shadow_prio[k + 1];
                        end
                        shadow_count--;
                        removals++;
                        r.status = ST_REMOVED;
                    end
                end
                pending_results.push_back(r);
            end
            CMD_LIST: begin
                if (shadow_count == 0) begin
                    r.status = ST_EMPTY;
                    pending_results.push_back(r);
                end else begin
                    // top to bottom, last flag on the bottom entry
                    for (int k = 0; k < shadow_count; k++) begin
                        r.status = ST_LISTED;
                        r.value_res = shadow_value[shadow_count - 1 - k];
                        r.priority_out = shadow_prio[shadow_count - 1 - k];
                        r.last = (k + 1 == shadow_count);
                        pending_results.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Present one command beat and hold it until the block takes it
    task automatic send_command(input logic [1:0] cmd, input logic signed [31:0] val,
                                input logic [7:0] prio);
        t_cmd_in c;
        c.command = cmd;
        c.value = val;
        c.priority_req = prio;
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        compute_stack_response(c);
        items_sent++;
    endtask

    // Drop start for a random burst of cycles, with junk on the command bus
    task automatic idle_sender(input int pct);
        int n;
        n = 0;
        while (n < 25 && $urandom_range(0, 99) < pct) begin
            start <= 1'b0;
            i_cmd <= {2'($urandom()), $urandom(), 8'($urandom())};
            @(posedge i_clk);
            n++;
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
        end
    endfunction

    // Compare each result beat with the oldest outstanding one
    always @(posedge i_clk) begin : check_results
        t_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: result beat with nothing outstanding, expected none, actual %p",
                         $time, o_result);
            end else begin
                want = pending_results.pop_front();
                check_field("status", want.status, o_result.status);
                check_field("value_res", want.value_res, o_result.value_res);
                check_field("priority_out", want.priority_out, o_result.priority_out);
                check_field("last", want.last, o_result.last);
                results_seen++;
            end
        end
    end

    // Abort when neither side moves a beat for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
                $display("tb: failure");
                $finish;
            end
        end
    end

    // Empty stack: list, remove and the unused code
    task automatic test_empty_stack();
        send_command(CMD_LIST, 32'sd0, 8'd0);
        send_command(CMD_REMOVE, 32'sd5, 8'd0);
        send_command(CMD_UNUSED, 32'sh7fff_ffff, 8'hff);
    endtask

    // Extreme values, first-match removal and a miss
    task automatic test_push_list_remove();
        send_command(CMD_PUSH, 32'sh7fff_ffff, 8'hff);
        send_command(CMD_PUSH, 32'sh8000_0000, 8'h00);
        send_command(CMD_PUSH, -32'sd1, 8'h00);
        send_command(CMD_LIST, 32'sd0, 8'd0);
        send_command(CMD_REMOVE, 32'sd0, 8'h00);
        send_command(CMD_REMOVE, 32'sd0, 8'h07);
        send_command(CMD_LIST, 32'sd0, 8'd0);
    endtask

    // Fill to the limit, refuse one more, list all, then pull the bottom entry
    task automatic test_fill_and_drain();
        while (shadow_count < DEPTH)
            send_command(CMD_PUSH, $urandom(), 8'd100 + 8'(shadow_count));
        send_command(CMD_PUSH, 32'sd1, 8'd1);
        send_command(CMD_LIST, 32'sd0, 8'd0);
        send_command(CMD_REMOVE, 32'sd0, 8'hff);
        send_command(CMD_LIST, 32'sd0, 8'd0);
    endtask

    // Random traffic; each stretch of ten leans toward pushing or removing
    task automatic test_random_traffic(input int n_items, input int idle_pct);
        int                 counted;
        int                 push_pct;
        int                 pick;
        logic [1:0]         cmd;
        logic signed [31:0] val;
        logic [7:0]         prio;
        counted = 0;
        push_pct = 50;
        while (counted < n_items) begin
            if (counted % 10 == 0) push_pct = $urandom_range(0, 1) ? 70 : 25;
            pick = $urandom_range(0, 99);
            if (pick < 4) cmd = CMD_UNUSED;
            else if (pick < 4 + push_pct) cmd = CMD_PUSH;
            else if (pick < 16 + push_pct) cmd = CMD_LIST;
            else cmd = CMD_REMOVE;
            case ($urandom_range(0, 9))
                0: val = 32'sh8000_0000;
                1: val = 32'sh7fff_ffff;
                2: val = -32'sd1;
                default: val = $urandom();
            endcase
            prio = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom_range(0, 255));
            // mostly aim removals at priorities that are present
            if (cmd == CMD_REMOVE && shadow_count > 0 && $urandom_range(0, 9) < 6)
                prio = shadow_prio[$urandom_range(0, shadow_count - 1)];
            send_command(cmd, val, prio);
            if (cmd != CMD_UNUSED) counted++;
            idle_sender(idle_pct);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_stack();
        test_push_list_remove();
        test_fill_and_drain();
        test_random_traffic(30, 0);
        test_random_traffic(30, 69);
        test_random_traffic(30, 36);

        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("sent %0d commands, checked %0d result beats", items_sent, results_seen);
        $display("%0d pushes refused when full, %0d removals, peak depth %0d",
                 refused_pushes, removals, peak_depth);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/swpd_pkg.sv
rtl/swpd_dp.sv
rtl/swpd_ctrl.sv
rtl/stack_with_priority_delete.sv
sim/tb_stack_with_priority_delete.sv
